/* rtl/eocs_pkg.sv */
// Package for the eight-op CPU step block: sizes, mode and opcode codes,
// status and controller state types, and the execute result bundle.
// No dependencies; every other file of the block but eocs_ram uses it.
`default_nettype none

package eocs_pkg;

  // Storage sizes.
  localparam int MEM_WORDS = 65536;
  localparam int REG_COUNT = 8;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int LOAD_W    = $clog2(MEM_WORDS + 1);
  localparam int REG_W     = $clog2(REG_COUNT);
  localparam int PC_W      = 16;
  localparam int WORD_W    = 32;

  // Instruction layout.
  localparam int OPC_SHIFT = 22;
  localparam int OPC_W     = 10;

  // Width of the address and target arithmetic, wide enough to never wrap.
  localparam int CALC_W    = 34;

  // Item modes.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Opcodes.
  localparam logic [OPC_W-1:0] OP_ADD  = 10'd0;
  localparam logic [OPC_W-1:0] OP_NOR  = 10'd1;
  localparam logic [OPC_W-1:0] OP_LW   = 10'd2;
  localparam logic [OPC_W-1:0] OP_SW   = 10'd3;
  localparam logic [OPC_W-1:0] OP_BEQ  = 10'd4;
  localparam logic [OPC_W-1:0] OP_JALR = 10'd5;
  localparam logic [OPC_W-1:0] OP_HALT = 10'd6;
  localparam logic [OPC_W-1:0] OP_NOOP = 10'd7;

  // Result and run status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HALTED      = 3'd1,
    ST_LW_RANGE    = 3'd2,
    ST_SW_RANGE    = 3'd3,
    ST_BEQ_TARGET  = 3'd4,
    ST_JALR_TARGET = 3'd5,
    ST_BAD_OPCODE  = 3'd6,
    ST_MEM_FULL    = 3'd7
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_LOAD
  } state_t;

  // What the execute unit decides for one instruction.
  typedef struct packed {
    status_t             err;
    logic                wr_valid;
    logic [REG_W-1:0]    wr_index;
    logic [WORD_W-1:0]   wr_value;
    logic [PC_W-1:0]     next_pc;
    logic [ADDR_W-1:0]   mem_idx;
    logic                is_lw;
    logic                is_sw;
    logic                is_halt;
  } exec_res_t;

endpackage

`default_nettype wire

/* rtl/eocs_ram.sv */
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
`default_nettype none

module eocs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic      [WIDTH-1:0]                       rdata_a,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                       rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* rtl/eocs_exec.sv */
// Execute unit: decodes one instruction word and works out its register
// write, next pc, memory index and range errors. Depends on eocs_pkg.
`default_nettype none

module eocs_exec (
  input  wire logic [eocs_pkg::WORD_W-1:0] instr,
  input  wire logic [eocs_pkg::WORD_W-1:0] va,
  input  wire logic [eocs_pkg::WORD_W-1:0] vb,
  input  wire logic [eocs_pkg::PC_W-1:0]   pc,
  input  wire logic [eocs_pkg::LOAD_W-1:0] loaded,
  output eocs_pkg::exec_res_t              res
);

  localparam int CW  = eocs_pkg::CALC_W;
  localparam int PXW = eocs_pkg::PC_W + 1;

  logic [eocs_pkg::OPC_W-1:0] op;
  logic [eocs_pkg::REG_W-1:0] ra;
  logic [eocs_pkg::REG_W-1:0] rb;
  logic [eocs_pkg::REG_W-1:0] rd;
  logic [PXW-1:0]             pc1;
  logic [CW-1:0]              off_x;
  logic [CW-1:0]              va_x;
  logic [CW-1:0]              pc1_x;
  logic [CW-1:0]              ls_addr;
  logic [CW-1:0]              br_tgt;
  logic [CW-1:0]              jr_tgt;
  logic                       ls_ok;
  logic                       br_ok;
  logic                       jr_ok;

  // An address is good when it is not negative and lies below the loaded count.
  function automatic logic in_range(input logic [CW-1:0] a,
                                    input logic [eocs_pkg::LOAD_W-1:0] n);
    return !a[CW-1] && (a < CW'(n));
  endfunction

  // Field extraction.
  assign op = instr[eocs_pkg::OPC_SHIFT +: eocs_pkg::OPC_W];
  assign ra = instr[21:19];
  assign rb = instr[18:16];
  assign rd = instr[eocs_pkg::REG_W-1:0];

  // Address and target arithmetic, widened so nothing wraps: offsets and va sign extended, pc + 1 zero extended.
  assign pc1     = {1'b0, pc} + PXW'(1);
  assign pc1_x   = CW'(pc1);
  assign off_x   = CW'($signed(instr[15:0]));
  assign va_x    = CW'($signed(va));
  assign ls_addr = va_x + off_x;
  assign br_tgt  = pc1_x + off_x;
  assign jr_tgt  = (ra == rb) ? pc1_x : va_x;
  assign ls_ok   = in_range(ls_addr, loaded);
  assign br_ok   = in_range(br_tgt, loaded);
  assign jr_ok   = in_range(jr_tgt, loaded);

  // Per-opcode decision.
  always_comb begin
    res          = '0;
    res.err      = eocs_pkg::ST_OK;
    res.next_pc  = pc1[eocs_pkg::PC_W-1:0];
    res.mem_idx  = ls_addr[eocs_pkg::ADDR_W-1:0];
    case (op)
      eocs_pkg::OP_ADD: begin
        res.wr_valid = 1'b1;
        res.wr_index = rd;
        res.wr_value = va + vb;
      end
      eocs_pkg::OP_NOR: begin
        res.wr_valid = 1'b1;
        res.wr_index = rd;
        res.wr_value = ~(va | vb);
      end
      eocs_pkg::OP_LW: begin
        if (!ls_ok) begin
          res.err = eocs_pkg::ST_LW_RANGE;
        end else begin
          res.is_lw    = 1'b1;
          res.wr_valid = 1'b1;
          res.wr_index = rb;
        end
      end
      eocs_pkg::OP_SW: begin
        if (!ls_ok) begin
          res.err = eocs_pkg::ST_SW_RANGE;
        end else begin
          res.is_sw = 1'b1;
        end
      end
      eocs_pkg::OP_BEQ: begin
        if (!br_ok) begin
          res.err = eocs_pkg::ST_BEQ_TARGET;
        end else if (va == vb) begin
          res.next_pc = br_tgt[eocs_pkg::PC_W-1:0];
        end
      end
      eocs_pkg::OP_JALR: begin
        if (!jr_ok) begin
          res.err = eocs_pkg::ST_JALR_TARGET;
        end else begin
          res.wr_valid = 1'b1;
          res.wr_index = rb;
          res.wr_value = eocs_pkg::WORD_W'(pc1);
          res.next_pc  = jr_tgt[eocs_pkg::PC_W-1:0];
        end
      end
      eocs_pkg::OP_HALT: begin
        res.is_halt = 1'b1;
      end
      eocs_pkg::OP_NOOP: begin
        res.is_halt = 1'b0;
      end
      default: begin
        res.err = eocs_pkg::ST_BAD_OPCODE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/eight_op_cpu_step_top.sv */
// Top level of the eight-op CPU step block: controller, state registers,
// word memory and register file RAMs. Depends on eocs_pkg, eocs_ram, eocs_exec.
//
// Usage:
// Input channel (in_valid / in_stall) carries mode and load_word. Mode load
// appends a word to memory, mode step executes the instruction at pc, mode
// clear returns the machine to its reset state. Every accepted item yields
// exactly one result on the output channel (out_valid / out_stall) with
// status, pc, instr_count and the register write of that item.
// Latency: load, clear, an unused mode and a step while stopped give their
// result one cycle after the transfer. A running step does its fetch read,
// register file read and execute through the decode and execute states; lw
// adds a load state for its data read from word memory. The next item is taken
// once the previous one has finished, so a new step waits for the last one,
// and loads run at one per cycle while the receiver does not stall.
// The result sits in an output register. While the receiver stalls it holds
// its value; a running step may still be taken and runs up to its commit
// point, where it waits for the output register to free up.
// Reset (rst, synchronous) clears pc, counters, run status and the register
// file valid bits. Word memory is not cleared: only loaded entries are read.
`default_nettype none

module eight_op_cpu_step_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          mode,
  input  wire logic signed [eocs_pkg::WORD_W-1:0]  load_word,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [2:0]                               status,
  output logic [eocs_pkg::PC_W-1:0]                pc,
  output logic [eocs_pkg::WORD_W-1:0]              instr_count,
  output logic                                     reg_write_valid,
  output logic [eocs_pkg::REG_W-1:0]               reg_write_index,
  output logic signed [eocs_pkg::WORD_W-1:0]       reg_write_value
);

  localparam int PXW = eocs_pkg::PC_W + 1;
  localparam int AW  = eocs_pkg::ADDR_W;
  localparam int LW  = eocs_pkg::LOAD_W;
  localparam int RW  = eocs_pkg::REG_W;
  localparam int WW  = eocs_pkg::WORD_W;

  eocs_pkg::state_t    state;
  eocs_pkg::state_t    state_next;
  eocs_pkg::status_t   run_status;
  eocs_pkg::status_t   run_status_next;
  eocs_pkg::status_t   o_status;
  eocs_pkg::exec_res_t res;

  logic [eocs_pkg::PC_W-1:0]      pc_r;
  logic [eocs_pkg::PC_W-1:0]      pc_next;
  logic [LW-1:0]                  loaded;
  logic [LW-1:0]                  loaded_next;
  logic [WW-1:0]                  count;
  logic [WW-1:0]                  count_next;
  logic [WW-1:0]                  count_inc;
  logic [eocs_pkg::REG_COUNT-1:0] reg_valid;
  logic [eocs_pkg::REG_COUNT-1:0] reg_valid_next;
  logic                           fetch_ok;
  logic [WW-1:0]                  instr_q;
  logic [WW-1:0]                  fetch_word;

  logic in_fire;
  logic step_run;
  logic imm_fire;
  logic slot_free;
  logic exec_done;
  logic lw_done;

  // Memory ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [WW-1:0] mem_rdata_a;
  logic [WW-1:0] mem_rdata_b;
  logic          rf_we;
  logic [RW-1:0] rf_waddr;
  logic [WW-1:0] rf_wdata;
  logic [RW-1:0] rf_raddr_a;
  logic [RW-1:0] rf_raddr_b;
  logic [WW-1:0] rf_rdata_a;
  logic [WW-1:0] rf_rdata_b;
  logic [WW-1:0] va;
  logic [WW-1:0] vb;

  // Result payload being committed this cycle.
  logic          o_wv;
  logic [RW-1:0] o_wi;
  logic [WW-1:0] o_wval;

  // Word memory: port A fetches at pc, port B reads lw data.
  eocs_ram #(
    .WIDTH (WW),
    .DEPTH (eocs_pkg::MEM_WORDS)
  ) u_word_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (pc_r[AW-1:0]),
    .rdata_a (mem_rdata_a),
    .raddr_b (res.mem_idx),
    .rdata_b (mem_rdata_b)
  );

  // Register file; entries not yet written read as zero via the valid bits.
  eocs_ram #(
    .WIDTH (WW),
    .DEPTH (eocs_pkg::REG_COUNT)
  ) u_reg_file (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata),
    .raddr_a (rf_raddr_a),
    .rdata_a (rf_rdata_a),
    .raddr_b (rf_raddr_b),
    .rdata_b (rf_rdata_b)
  );

  // Fetched word reads as zero outside the loaded words.
  assign fetch_word = fetch_ok ? mem_rdata_a : '0;

  // Register reads: addresses come from the fetched word while decoding and
  // from the held instruction afterwards, which keeps the read data stable.
  assign rf_raddr_a = (state == eocs_pkg::S_DECODE) ? fetch_word[21:19] : instr_q[21:19];
  assign rf_raddr_b = (state == eocs_pkg::S_DECODE) ? fetch_word[18:16] : instr_q[18:16];
  assign va = reg_valid[instr_q[21:19]] ? rf_rdata_a : '0;
  assign vb = reg_valid[instr_q[18:16]] ? rf_rdata_b : '0;

  eocs_exec u_exec (
    .instr  (instr_q),
    .va     (va),
    .vb     (vb),
    .pc     (pc_r),
    .loaded (loaded),
    .res    (res)
  );

  assign count_inc = (count == '1) ? count : count + WW'(1);

  // Handshake and commit control.
  always_comb begin
    slot_free = !out_valid || !out_stall;
    step_run  = (mode == eocs_pkg::MODE_STEP) && (run_status == eocs_pkg::ST_OK);
    in_stall  = !((state == eocs_pkg::S_IDLE) && (slot_free || step_run));
    in_fire   = in_valid && !in_stall;
    imm_fire  = in_fire && !step_run;
    exec_done = (state == eocs_pkg::S_EXEC) && !res.is_lw && slot_free;
    lw_done   = (state == eocs_pkg::S_LOAD) && slot_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      eocs_pkg::S_IDLE: begin
        if (in_fire && step_run) begin
          state_next = eocs_pkg::S_DECODE;
        end
      end
      eocs_pkg::S_DECODE: begin
        state_next = eocs_pkg::S_EXEC;
      end
      eocs_pkg::S_EXEC: begin
        if (res.is_lw) begin
          state_next = eocs_pkg::S_LOAD;
        end else if (slot_free) begin
          state_next = eocs_pkg::S_IDLE;
        end
      end
      eocs_pkg::S_LOAD: begin
        if (slot_free) begin
          state_next = eocs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = eocs_pkg::S_IDLE;
      end
    endcase
  end

  // Commit of machine state and the result payload.
  always_comb begin
    pc_next         = pc_r;
    loaded_next     = loaded;
    count_next      = count;
    run_status_next = run_status;
    reg_valid_next  = reg_valid;
    o_status        = run_status;
    o_wv            = 1'b0;
    o_wi            = '0;
    o_wval          = '0;
    mem_we          = 1'b0;
    mem_waddr       = loaded[AW-1:0];
    mem_wdata       = load_word;
    rf_we           = 1'b0;
    rf_waddr        = res.wr_index;
    rf_wdata        = res.wr_value;
    if (imm_fire) begin
      case (mode)
        eocs_pkg::MODE_LOAD: begin
          if (loaded < LW'(eocs_pkg::MEM_WORDS)) begin
            mem_we      = 1'b1;
            loaded_next = loaded + LW'(1);
            o_status    = eocs_pkg::ST_OK;
          end else begin
            o_status = eocs_pkg::ST_MEM_FULL;
          end
        end
        eocs_pkg::MODE_CLEAR: begin
          pc_next         = '0;
          loaded_next     = '0;
          count_next      = '0;
          run_status_next = eocs_pkg::ST_OK;
          reg_valid_next  = '0;
          o_status        = eocs_pkg::ST_OK;
        end
        default: begin
          o_status = run_status;
        end
      endcase
    end else if (exec_done) begin
      if (res.err != eocs_pkg::ST_OK) begin
        run_status_next = res.err;
        o_status        = res.err;
      end else begin
        pc_next    = res.next_pc;
        count_next = count_inc;
        if (res.wr_valid) begin
          rf_we                        = 1'b1;
          reg_valid_next[res.wr_index] = 1'b1;
          o_wv                         = 1'b1;
          o_wi                         = res.wr_index;
          o_wval                       = res.wr_value;
        end
        if (res.is_sw) begin
          mem_we    = 1'b1;
          mem_waddr = res.mem_idx;
          mem_wdata = vb;
        end
        if (res.is_halt) begin
          run_status_next = eocs_pkg::ST_HALTED;
        end
        o_status = run_status_next;
      end
    end else if (lw_done) begin
      pc_next                      = res.next_pc;
      count_next                   = count_inc;
      rf_we                        = 1'b1;
      rf_wdata                     = mem_rdata_b;
      reg_valid_next[res.wr_index] = 1'b1;
      o_wv                         = 1'b1;
      o_wi                         = res.wr_index;
      o_wval                       = mem_rdata_b;
      o_status                     = run_status;
    end
  end

  // Control and machine state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= eocs_pkg::S_IDLE;
      pc_r       <= '0;
      loaded     <= '0;
      count      <= '0;
      run_status <= eocs_pkg::ST_OK;
      reg_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pc_r       <= pc_next;
      loaded     <= loaded_next;
      count      <= count_next;
      run_status <= run_status_next;
      reg_valid  <= reg_valid_next;
      if (imm_fire || exec_done || lw_done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Fetch bookkeeping and the held instruction word.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fetch_ok <= {1'b0, pc_r} < PXW'(loaded);
    end
    if (state == eocs_pkg::S_DECODE) begin
      instr_q <= fetch_word;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (imm_fire || exec_done || lw_done) begin
      status          <= o_status;
      pc              <= pc_next;
      instr_count     <= count_next;
      reg_write_valid <= o_wv;
      reg_write_index <= o_wi;
      reg_write_value <= o_wval;
    end
  end

endmodule

`default_nettype wire

/* rtl/eocs_checker.sv */
// Port-level checker for the eight-op CPU step block, bound to its top level.
// Depends on eocs_pkg and eight_op_cpu_step_top.
`default_nettype none

module eocs_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic [1:0]                          mode,
  input wire logic signed [eocs_pkg::WORD_W-1:0]  load_word,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic [2:0]                          status,
  input wire logic [eocs_pkg::PC_W-1:0]           pc,
  input wire logic [eocs_pkg::WORD_W-1:0]         instr_count,
  input wire logic                                reg_write_valid,
  input wire logic [eocs_pkg::REG_W-1:0]          reg_write_index,
  input wire logic signed [eocs_pkg::WORD_W-1:0]  reg_write_value
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(pc) &&
      $stable(instr_count) && $stable(reg_write_valid) &&
      $stable(reg_write_index) && $stable(reg_write_value))
    else $error("stalled result changed");

  // A load transfer yields its result on the next cycle.
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == eocs_pkg::MODE_LOAD) |=> out_valid)
    else $error("load result missing");

  // A clear transfer reports a reset machine.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == eocs_pkg::MODE_CLEAR) |=>
      out_valid && (status == eocs_pkg::ST_OK) && (pc == '0) && (instr_count == '0))
    else $error("clear result wrong");

  // Without a register write the write fields are zero.
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reg_write_valid |-> (reg_write_index == '0) && (reg_write_value == '0))
    else $error("register write fields not zero");

endmodule

bind eight_op_cpu_step_top eocs_checker u_eocs_checker (.*);

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for eight_op_cpu_step_top: a directed table, partly with fixed expected
// results, and random programs, checked against an in-bench model of the machine.
// Depends on eocs_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 3000000;

  // One result of the block, as the model predicts it.
  typedef struct packed {
    eocs_pkg::status_t st;
    logic [15:0]       pc;
    logic [31:0]       cnt;
    logic              wv;
    logic [2:0]        wi;
    logic [31:0]       wval;
  } outcome_t;

  // One row of the directed table.
  typedef struct packed {
    logic [1:0]  m;
    logic [31:0] w;
    logic        typed;
    outcome_t    want;
  } stim_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = eocs_pkg::MODE_LOAD;
  logic signed [31:0] load_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic [15:0]        pc;
  logic [31:0]        instr_count;
  logic               reg_write_valid;
  logic [2:0]         reg_write_index;
  logic signed [31:0] reg_write_value;

  // Architectural state of the machine as the bench sees it.
  logic [31:0]       arch_mem [0:eocs_pkg::MEM_WORDS-1];
  logic [31:0]       arch_regs [0:eocs_pkg::REG_COUNT-1];
  logic [15:0]       arch_pc;
  logic [16:0]       arch_loaded;
  logic [31:0]       arch_count;
  eocs_pkg::status_t arch_run;

  outcome_t    pending_results [$];
  stim_row_t   dir_rows [$];
  int          errors = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;

  eight_op_cpu_step_top u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .load_word       (load_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .pc              (pc),
    .instr_count     (instr_count),
    .reg_write_valid (reg_write_valid),
    .reg_write_index (reg_write_index),
    .reg_write_value (reg_write_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void clear_arch();
    for (int i = 0; i < eocs_pkg::REG_COUNT; i++) arch_regs[i] = '0;
    arch_pc     = '0;
    arch_loaded = '0;
    arch_count  = '0;
    arch_run    = eocs_pkg::ST_OK;
  endfunction

  function automatic bit in_loaded(input longint a);
    return a >= 0 && a < longint'(arch_loaded);
  endfunction

  // Applies one input item to the architectural state and returns its result.
  function automatic outcome_t predict_step(input logic [1:0] m, input logic [31:0] w);
    outcome_t                   r;
    eocs_pkg::status_t          st;
    eocs_pkg::status_t          fault;
    logic [31:0]                iw, va, vb, wval;
    logic [eocs_pkg::OPC_W-1:0] op;
    logic [2:0]                 ra, rb, wi;
    logic                       wv;
    logic [15:0]                nxt;
    longint                     off, addr;
    st = arch_run;
    wv = 1'b0;
    wi = '0;
    wval = '0;
    case (m)
      eocs_pkg::MODE_LOAD: begin
        if (arch_loaded < eocs_pkg::MEM_WORDS) begin
          arch_mem[arch_loaded[15:0]] = w;
          arch_loaded = arch_loaded + 17'd1;
          st = eocs_pkg::ST_OK;
        end else begin
          st = eocs_pkg::ST_MEM_FULL;
        end
      end
      eocs_pkg::MODE_CLEAR: begin
        clear_arch();
        st = eocs_pkg::ST_OK;
      end
      eocs_pkg::MODE_STEP: begin
        if (arch_run == eocs_pkg::ST_OK) begin
          // A fetch beyond the loaded words reads as zero, an add.
          iw = (arch_pc < arch_loaded) ? arch_mem[arch_pc] : '0;
          op = iw[31:22];
          ra = iw[21:19];
          rb = iw[18:16];
          va = arch_regs[ra];
          vb = arch_regs[rb];
          off = longint'($signed(iw[15:0]));
          nxt = arch_pc + 16'd1;
          fault = eocs_pkg::ST_OK;
          case (op)
            eocs_pkg::OP_ADD, eocs_pkg::OP_NOR: begin
              wv = 1'b1;
              wi = iw[2:0];
              wval = (op == eocs_pkg::OP_ADD) ? va + vb : ~(va | vb);
            end
            eocs_pkg::OP_LW, eocs_pkg::OP_SW: begin
              addr = longint'($signed(va)) + off;
              if (!in_loaded(addr)) begin
                fault = (op == eocs_pkg::OP_LW) ? eocs_pkg::ST_LW_RANGE
                                                : eocs_pkg::ST_SW_RANGE;
              end else if (op == eocs_pkg::OP_LW) begin
                wv = 1'b1;
                wi = rb;
                wval = arch_mem[addr[15:0]];
              end else begin
                arch_mem[addr[15:0]] = vb;
              end
            end
            eocs_pkg::OP_BEQ: begin
              // The target is checked whether or not the branch is taken.
              addr = longint'(arch_pc) + 1 + off;
              if (!in_loaded(addr)) fault = eocs_pkg::ST_BEQ_TARGET;
              else if (va == vb) nxt = addr[15:0];
            end
            eocs_pkg::OP_JALR: begin
              addr = (ra == rb) ? longint'(arch_pc) + 1 : longint'($signed(va));
              if (!in_loaded(addr)) begin
                fault = eocs_pkg::ST_JALR_TARGET;
              end else begin
                wv = 1'b1;
                wi = rb;
                wval = {16'd0, arch_pc} + 32'd1;
                nxt = addr[15:0];
              end
            end
            eocs_pkg::OP_HALT, eocs_pkg::OP_NOOP: ;
            default: fault = eocs_pkg::ST_BAD_OPCODE;
          endcase
          // A faulting instruction leaves everything but the run status alone.
          if (fault != eocs_pkg::ST_OK) begin
            wv = 1'b0;
            wi = '0;
            wval = '0;
            arch_run = fault;
          end else begin
            if (wv) arch_regs[wi] = wval;
            arch_pc = nxt;
            if (arch_count != '1) arch_count = arch_count + 32'd1;
            if (op == eocs_pkg::OP_HALT) arch_run = eocs_pkg::ST_HALTED;
          end
          st = arch_run;
        end
      end
      default: ;
    endcase
    r.st   = st;
    r.pc   = arch_pc;
    r.cnt  = arch_count;
    r.wv   = wv;
    r.wi   = wi;
    r.wval = wval;
    return r;
  endfunction

  function automatic int idle_cycles();
    return quiet ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic logic [31:0] encode(input logic [eocs_pkg::OPC_W-1:0] op,
                                         input logic [2:0] ra, input logic [2:0] rb,
                                         input logic [15:0] low);
    return {op, ra, rb, low};
  endfunction

  // Random program word: mostly valid instructions with offsets near the
  // program, some bad opcodes, small data values and raw noise.
  function automatic logic [31:0] program_word(input int n);
    int                         pick;
    logic [eocs_pkg::OPC_W-1:0] op;
    logic [2:0]                 ra, rb;
    logic [15:0]                low;
    pick = $urandom_range(0, 99);
    if (pick < 10) return $urandom;
    if (pick < 20) return $urandom_range(0, n + 2);
    if (pick < 25) op = eocs_pkg::OPC_W'($urandom_range(8, 1023));
    else op = eocs_pkg::OPC_W'($urandom_range(0, 7));
    if (op == eocs_pkg::OP_HALT && $urandom_range(0, 2) != 0) op = eocs_pkg::OP_NOOP;
    ra = 3'($urandom_range(0, 7));
    rb = ($urandom_range(0, 3) == 0) ? ra : 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) low = 16'($urandom);
    else low = 16'($urandom_range(0, 2 * n)) - 16'(n);
    return encode(op, ra, rb, low);
  endfunction

  function automatic stim_row_t plain_row(input logic [1:0] m, input logic [31:0] w);
    stim_row_t r;
    r = '0;
    r.m = m;
    r.w = w;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(input logic [1:0] m, input logic [31:0] w,
                                          input eocs_pkg::status_t st,
                                          input logic [15:0] p,
                                          input logic [31:0] cnt, input logic wv);
    stim_row_t r;
    r = plain_row(m, w);
    r.typed = 1'b1;
    r.want.st = st;
    r.want.pc = p;
    r.want.cnt = cnt;
    r.want.wv = wv;
    return r;
  endfunction

  // Drives one item, waits for its transfer and records what it should give.
  task automatic send_item(input logic [1:0] m, input logic [31:0] w, input logic typed,
                           input outcome_t fixed);
    int       gap;
    outcome_t pred;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    load_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_step(m, w);
    pending_results.push_back(typed ? fixed : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [1:0] m, input logic [31:0] w);
    send_item(m, w, 1'b0, '0);
  endtask

  // Holds the sender idle until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, fname, want, got);
      errors++;
    end
  endtask

  // Receiver: random stall before each result transfer.
  initial begin : result_sink
    int hold;
    forever begin
      hold = idle_cycles();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.st), 32'(status));
        check_field("pc", 32'(want.pc), 32'(pc));
        check_field("instr_count", want.cnt, instr_count);
        check_field("reg_write_valid", 32'(want.wv), 32'(reg_write_valid));
        check_field("reg_write_index", 32'(want.wi), 32'(reg_write_index));
        check_field("reg_write_value", want.wval, reg_write_value);
      end
    end
  end

  initial begin : stimulus
    int start, n, steps, pick;
    bit first;
    clear_arch();

    // Directed program: every opcode but noop, a lw range fault, stepping while
    // stopped, loading while stopped, a bad opcode and halt.
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_STEP, '0, eocs_pkg::ST_OK,
                                 16'd1, 32'd1, 1'b1));
    dir_rows.push_back(fixed_row(MODE_UNUSED, '1, eocs_pkg::ST_OK, 16'd1, 32'd1, 1'b0));
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_CLEAR, '0, eocs_pkg::ST_OK, '0, '0, 1'b0));
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_LOAD,
                                 encode(eocs_pkg::OP_LW, 3'd0, 3'd1, 16'd7),
                                 eocs_pkg::ST_OK, '0, '0, 1'b0));
    dir_rows.push_back(plain_row(eocs_pkg::MODE_LOAD,
                                 encode(eocs_pkg::OP_NOR, 3'd1, 3'd0, 16'd2)));
    dir_rows.push_back(plain_row(eocs_pkg::MODE_LOAD,
                                 encode(eocs_pkg::OP_ADD, 3'd1, 3'd1, 16'd3)));
    dir_rows.push_back(plain_row(eocs_pkg::MODE_LOAD,
                                 encode(eocs_pkg::OP_SW, 3'd0, 3'd2, 16'd8)));
    dir_rows.push_back(plain_row(eocs_pkg::MODE_LOAD,
                                 encode(eocs_pkg::OP_BEQ, 3'd0, 3'd0, 16'd0)));
    dir_rows.push_back(plain_row(eocs_pkg::MODE_LOAD,
                                 encode(eocs_pkg::OP_JALR, 3'd4, 3'd4, 16'd0)));
    dir_rows.push_back(plain_row(eocs_pkg::MODE_LOAD,
                                 encode(eocs_pkg::OP_LW, 3'd1, 3'd5, 16'hFFFF)));
    dir_rows.push_back(plain_row(eocs_pkg::MODE_LOAD, 32'h7FFF_FFFF));
    dir_rows.push_back(plain_row(eocs_pkg::MODE_LOAD, 32'h8000_0000));
    repeat (6) dir_rows.push_back(plain_row(eocs_pkg::MODE_STEP, '0));
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_STEP, '0, eocs_pkg::ST_LW_RANGE,
                                 16'd6, 32'd6, 1'b0));
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_STEP, '1, eocs_pkg::ST_LW_RANGE,
                                 16'd6, 32'd6, 1'b0));
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_LOAD, '1, eocs_pkg::ST_OK,
                                 16'd6, 32'd6, 1'b0));
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_CLEAR, '0, eocs_pkg::ST_OK, '0, '0, 1'b0));
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_LOAD, '1, eocs_pkg::ST_OK, '0, '0, 1'b0));
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_STEP, '0, eocs_pkg::ST_BAD_OPCODE,
                                 '0, '0, 1'b0));
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_CLEAR, '0, eocs_pkg::ST_OK, '0, '0, 1'b0));
    dir_rows.push_back(plain_row(eocs_pkg::MODE_LOAD,
                                 encode(eocs_pkg::OP_HALT, 3'd0, 3'd0, 16'd0)));
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_STEP, '0, eocs_pkg::ST_HALTED,
                                 16'd1, 32'd1, 1'b0));
    dir_rows.push_back(fixed_row(eocs_pkg::MODE_STEP, '0, eocs_pkg::ST_HALTED,
                                 16'd1, 32'd1, 1'b0));

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].m, dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

    // Random programs: clear, load, run, with stray loads, clears and
    // unused modes mixed into the run.
    start = items_sent;
    first = 1'b1;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (first || $urandom_range(0, 3) == 0) drain();
      quiet = ($urandom_range(0, 4) == 0);
      if (first || $urandom_range(0, 9) != 0) send_plain(eocs_pkg::MODE_CLEAR, $urandom);
      first = 1'b0;
      n = $urandom_range(3, 24);
      repeat (n) send_plain(eocs_pkg::MODE_LOAD, program_word(n));
      steps = $urandom_range(5, 40);
      repeat (steps) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) send_plain(MODE_UNUSED, $urandom);
        else if (pick < 6) send_plain(eocs_pkg::MODE_LOAD, program_word(n));
        else if (pick < 8) send_plain(eocs_pkg::MODE_CLEAR, $urandom);
        else send_plain(eocs_pkg::MODE_STEP, $urandom);
      end
      quiet = 1'b0;
    end
    in_valid <= 1'b0;

    // Let the last results drain, then watch a little longer for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* eight_op_cpu_step_top.f */
rtl/eocs_pkg.sv
rtl/eocs_ram.sv
rtl/eocs_exec.sv
rtl/eight_op_cpu_step_top.sv
rtl/eocs_checker.sv
tb/sv/tb.sv
